FILE: rtl/core/sle_pkg.sv
// Shared types and codes of the sorted list engine.
// No dependencies; sle_mem, sle_ctrl and the top level import this package.
package sle_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_POP    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ValueW-1:0] value;
  } sle_req_t;

  typedef struct packed {
    status_e           status;
    logic [ValueW-1:0] popped_value;
    logic [CountW-1:0] entry_count;
  } sle_res_t;

endpackage

FILE: rtl/core/sle_if.sv
// Valid/ready channel interfaces of the sorted list engine: request and response.
// No dependencies.
interface sle_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface sle_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] popped_value;
  logic [4:0]         entry_count;

  modport source (output valid, output status, output popped_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input popped_value, input entry_count,
                  output ready);
endinterface

FILE: rtl/core/sle_mem.sv
// Entry store of the sorted list engine: one write port, one read port,
// read data registered. Depends on sle_pkg.
module sle_mem
  import sle_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16,
  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [ValueW-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [ValueW-1:0] rdata_o
);

  logic [ValueW-1:0] mem_q [TABLE_DEPTH];
  logic [ValueW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/sle_ctrl.sv
// Sequencer of the sorted list engine: walks the entry store one entry per
// cycle, shifting entries up on insert and down on delete or pop. Depends on sle_pkg.
module sle_ctrl
  import sle_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16,
  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  sle_req_t          req_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output sle_res_t          res_o,
  output logic              mem_we_o,
  output logic [AddrW-1:0]  mem_waddr_o,
  output logic [ValueW-1:0] mem_wdata_o,
  output logic              mem_re_o,
  output logic [AddrW-1:0]  mem_raddr_o,
  input  logic [ValueW-1:0] mem_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_INS,
    S_INS0,
    S_DONE
  } state_e;

  localparam logic [CntW-1:0] CntFull = CntW'(TABLE_DEPTH);

  state_e            state_q, state_d;
  kind_e             op_q, op_d;
  logic [ValueW-1:0] val_q, val_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [AddrW-1:0]  didx_q, didx_d;
  logic              rvalid_q, rvalid_d;
  logic              found_q, found_d;
  status_e           status_q, status_d;
  logic [ValueW-1:0] popped_q, popped_d;

  logic [CntW-1:0]   cnt_m1;
  logic              data_eq;
  logic              data_last;
  logic              hit_now;

  assign cnt_m1    = cnt_q - CntW'(1);
  assign data_eq   = (mem_rdata_i == val_q);
  assign data_last = (CntW'(didx_q) == cnt_m1);
  assign hit_now   = (op_q == KIND_POP) ? (didx_q == '0) : data_eq;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    val_d       = val_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    didx_d      = didx_q;
    rvalid_d    = 1'b0;
    found_d     = found_q;
    status_d    = status_q;
    popped_d    = popped_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = val_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q[AddrW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_d     = kind_e'(req_i.kind);
          val_d    = req_i.value;
          found_d  = 1'b0;
          popped_d = '0;
          status_d = ST_OK;
          unique case (kind_e'(req_i.kind))
            KIND_INSERT: begin
              if (cnt_q == CntFull) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else if (cnt_q == '0) begin
                state_d = S_INS0;
              end else begin
                // start from the top entry and walk down
                mem_re_o    = 1'b1;
                mem_raddr_o = cnt_m1[AddrW-1:0];
                didx_d      = cnt_m1[AddrW-1:0];
                state_d     = S_INS;
              end
            end
            KIND_SEARCH, KIND_DELETE, KIND_POP: begin
              if (cnt_q == '0) begin
                status_d = (kind_e'(req_i.kind) == KIND_SEARCH) ? ST_NOT_FOUND : ST_EMPTY;
                state_d  = S_DONE;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = '0;
                idx_d       = CntW'(1);
                didx_d      = '0;
                rvalid_d    = 1'b1;
                state_d     = S_SCAN;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_SCAN: begin
        // keep one read in flight ahead of the entry under test
        if (idx_q < cnt_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q[AddrW-1:0];
          idx_d       = idx_q + CntW'(1);
          didx_d      = idx_q[AddrW-1:0];
          rvalid_d    = 1'b1;
        end
        if (rvalid_q) begin
          if (op_q == KIND_SEARCH) begin
            if (data_eq) begin
              status_d = ST_OK;
              state_d  = S_DONE;
            end else if (data_last) begin
              status_d = ST_NOT_FOUND;
              state_d  = S_DONE;
            end
          end else begin
            if (found_q) begin
              // close the gap: move this entry one place down
              mem_we_o    = 1'b1;
              mem_waddr_o = didx_q - AddrW'(1);
              mem_wdata_o = mem_rdata_i;
            end else if (hit_now) begin
              found_d  = 1'b1;
              popped_d = (op_q == KIND_POP) ? mem_rdata_i : '0;
            end
            if (data_last) begin
              if (found_q || hit_now) begin
                cnt_d    = cnt_m1;
                status_d = ST_OK;
              end else begin
                status_d = ST_NOT_FOUND;
              end
              state_d = S_DONE;
            end
          end
        end
      end

      S_INS: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = didx_q + AddrW'(1);
        if ($signed(mem_rdata_i) >= $signed(val_q)) begin
          // entry moves up one place; keep walking down
          mem_wdata_o = mem_rdata_i;
          if (didx_q == '0) begin
            state_d = S_INS0;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = didx_q - AddrW'(1);
            didx_d      = didx_q - AddrW'(1);
          end
        end else begin
          mem_wdata_o = val_q;
          cnt_d       = cnt_q + CntW'(1);
          status_d    = ST_OK;
          state_d     = S_DONE;
        end
      end

      S_INS0: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = '0;
        mem_wdata_o = val_q;
        cnt_d       = cnt_q + CntW'(1);
        status_d    = ST_OK;
        state_d     = S_DONE;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      rvalid_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rvalid_q <= rvalid_d;
      found_q  <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    val_q    <= val_d;
    idx_q    <= idx_d;
    didx_q   <= didx_d;
    status_q <= status_d;
    popped_q <= popped_d;
  end

  assign req_ready_o        = (state_q == S_IDLE);
  assign res_valid_o        = (state_q == S_DONE);
  assign res_o.status       = status_q;
  assign res_o.popped_value = popped_q;
  assign res_o.entry_count  = CountW'(cnt_q);

  // table never grows past its depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("entry count above table depth");

  // writes land at or below the current fill level
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (CntW'(mem_waddr_o) <= cnt_q))
    else $error("write beyond fill level");

  // a read never hits the entry being written in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && mem_re_o) |-> (mem_waddr_o != mem_raddr_o))
    else $error("read and write to the same entry");

  // a full report only comes from a full table
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && status_q == ST_FULL) |-> (cnt_q == CntFull))
    else $error("full status with room left");

  // each insert that ends at the bottom entry grows the table by exactly one
  a_ins_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS0) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("insert did not grow table by one");

endmodule

FILE: rtl/core/sorted_list_engine_top.sv
// Top level of the sorted list engine: sequencer, entry store and response register.
// Depends on sle_pkg, sle_if (sle_req_if, sle_rsp_if), sle_ctrl and sle_mem.
//
//   channel  dir  beat fields                           handshake
//   req_i    in   kind[1:0], value[31:0] signed         valid/ready
//   rsp_o    out  status[1:0], popped_value[31:0] s,    valid/ready
//                 entry_count[4:0]
//
// Sequencing: one request at a time. The single read port of the entry store visits one
//   entry per cycle while the sequencer tests it and, on insert, delete or pop, writes it
//   back one place up or down. Insert into a full table, and delete or pop on an empty
//   one, go straight to the response without a read of the store.
// Reset: rst_ni low clears the entry count and the control state; the store itself
//   needs no clearing since only entries below the count are ever read.
// Stalls: a finished response waits in the output register; the next request is taken
//   meanwhile, and its result waits in the sequencer until the output register frees.
module sorted_list_engine_top
  import sle_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sle_req_if.sink   req_i,
  sle_rsp_if.source rsp_o
);

  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  sle_req_t          req;
  sle_res_t          res;
  logic              res_valid;
  logic              res_ready;

  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [ValueW-1:0] mem_wdata;
  logic              mem_re;
  logic [AddrW-1:0]  mem_raddr;
  logic [ValueW-1:0] mem_rdata;

  logic              out_valid_q;
  sle_res_t          out_q;

  // pack the request beat for the sequencer
  assign req.kind  = req_i.kind;
  assign req.value = req_i.value;

  sle_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  sle_mem #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Response register: load a finished result when empty or being drained,
  // drop the held beat once the sink takes it.
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.popped_value = out_q.popped_value;
  assign rsp_o.entry_count  = out_q.entry_count;

endmodule
